FILE: rtl/kvd_pkg.sv
// ----------------------------------------------------------------------------
// kvd_pkg : keyframe vertex decode and lerp, shared definitions
// Widths, the quarter-wave sine table, angle lookup and the queue entry type.
// ----------------------------------------------------------------------------
package kvd_pkg;

   localparam int TRIG_FRAC_BITS = 14;
   localparam int ANGLE_STEPS    = 256;
   localparam int ANGLE_BITS     = $clog2(ANGLE_STEPS);
   localparam int HALF_TURN      = ANGLE_STEPS / 2;
   localparam int QUARTER_TURN   = ANGLE_STEPS / 4;
   localparam int QIDX_W         = $clog2(QUARTER_TURN + 1);
   localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
   localparam int TPROD_W        = 2 * TRIG_W;

   localparam int POS_IN_W   = 16;
   localparam int POS_DLT_W  = POS_IN_W + 1;
   localparam int POS_OUT_W  = 24;
   localparam int POS_FRAC   = 8;
   localparam int NRM_W      = 16;
   localparam int NRM_DLT_W  = NRM_W + 1;
   localparam int FACT_W     = 17;
   localparam int LERP_SHIFT = 16;
   localparam int ONE_Q16    = 1 << LERP_SHIFT;
   localparam int LPROD_W    = FACT_W + 1 + POS_DLT_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam longint PI_Q30 = 64'sd3373259426;

   typedef logic signed [TRIG_W-1:0]        trig_type;
   typedef logic [QUARTER_TURN:0][TRIG_W-1:0] quarter_type;

   typedef struct packed {
      logic signed [POS_IN_W-1:0]  cur_x;
      logic signed [POS_IN_W-1:0]  cur_y;
      logic signed [POS_IN_W-1:0]  cur_z;
      logic signed [POS_DLT_W-1:0] dlt_x;
      logic signed [POS_DLT_W-1:0] dlt_y;
      logic signed [POS_DLT_W-1:0] dlt_z;
      logic signed [NRM_W-1:0]     ncur_x;
      logic signed [NRM_W-1:0]     ncur_y;
      logic signed [NRM_W-1:0]     ncur_z;
      logic signed [NRM_W-1:0]     nnext_x;
      logic signed [NRM_W-1:0]     nnext_y;
      logic signed [NRM_W-1:0]     nnext_z;
   } entry_type;

   // non-negative quotient by restoring long division; elaboration only
   function automatic longint div_const(input longint num, input longint den);
      logic [63:0] n_u;
      logic [63:0] d_u;
      logic [63:0] rem;
      logic [63:0] quo;
      n_u = 64'(num);
      d_u = 64'(den);
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], n_u[i]};
         if (rem >= d_u) begin
            rem    = rem - d_u;
            quo[i] = 1'b1;
         end
      end
      return longint'(quo);
   endfunction

   // Taylor series in Q30, rounded to TRIG_FRAC_BITS; elaboration only
   function automatic quarter_type build_quarter_sine();
      quarter_type tab;
      longint      x;
      longint      x2;
      longint      term;
      longint      sum;
      longint      r;
      tab = '0;
      for (int k = 0; k <= QUARTER_TURN; k++) begin
         x    = (PI_Q30 * longint'(k)) >>> (ANGLE_BITS - 1);
         x2   = (x * x) >>> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= 12; n++) begin
            term = (term * x2) >>> 30;
            term = div_const(term, longint'((2 * n) * (2 * n + 1)));
            if ((n & 1) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         r = (sum + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
         if (r > (longint'(1) << TRIG_FRAC_BITS)) begin
            r = longint'(1) << TRIG_FRAC_BITS;
         end
         tab[k] = TRIG_W'(r);
      end
      return tab;
   endfunction

   localparam quarter_type QUARTER_SINE = build_quarter_sine();

   function automatic trig_type sine_at(input logic [ANGLE_BITS-1:0] k);
      logic [ANGLE_BITS-1:0] idx;
      logic                  neg;
      trig_type              mag;
      if (k <= ANGLE_BITS'(QUARTER_TURN)) begin
         idx = k;
         neg = 1'b0;
      end else if (k <= ANGLE_BITS'(HALF_TURN)) begin
         idx = ANGLE_BITS'(HALF_TURN) - k;
         neg = 1'b0;
      end else if (k <= ANGLE_BITS'(HALF_TURN + QUARTER_TURN)) begin
         idx = k - ANGLE_BITS'(HALF_TURN);
         neg = 1'b1;
      end else begin
         idx = ANGLE_BITS'(0) - k;
         neg = 1'b1;
      end
      mag = QUARTER_SINE[idx[QIDX_W-1:0]];
      return neg ? -mag : mag;
   endfunction

   function automatic trig_type cosine_at(input logic [ANGLE_BITS-1:0] k);
      return sine_at(k + ANGLE_BITS'(QUARTER_TURN));
   endfunction

endpackage

FILE: rtl/kvd_if.sv
// ----------------------------------------------------------------------------
// kvd_if : vertex pair and result channels
// Valid/ready channels carrying one vertex pair in and one lerped vertex out.
// ----------------------------------------------------------------------------
interface kvd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [kvd_pkg::POS_IN_W-1:0]  cur_x;
   logic signed [kvd_pkg::POS_IN_W-1:0]  cur_y;
   logic signed [kvd_pkg::POS_IN_W-1:0]  cur_z;
   logic [kvd_pkg::NRM_W-1:0]            cur_normal;
   logic signed [kvd_pkg::POS_IN_W-1:0]  next_x;
   logic signed [kvd_pkg::POS_IN_W-1:0]  next_y;
   logic signed [kvd_pkg::POS_IN_W-1:0]  next_z;
   logic [kvd_pkg::NRM_W-1:0]            next_normal;

   modport source(output valid, cur_x, cur_y, cur_z, cur_normal,
                  next_x, next_y, next_z, next_normal, input ready);
   modport sink(input valid, cur_x, cur_y, cur_z, cur_normal,
                next_x, next_y, next_z, next_normal, output ready);
endinterface

interface kvd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [kvd_pkg::POS_OUT_W-1:0] pos_x;
   logic signed [kvd_pkg::POS_OUT_W-1:0] pos_y;
   logic signed [kvd_pkg::POS_OUT_W-1:0] pos_z;
   logic signed [kvd_pkg::NRM_W-1:0]     nrm_x;
   logic signed [kvd_pkg::NRM_W-1:0]     nrm_y;
   logic signed [kvd_pkg::NRM_W-1:0]     nrm_z;

   modport source(output valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                  input ready);
   modport sink(input valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                output ready);
endinterface

FILE: rtl/kvd_front.sv
// ----------------------------------------------------------------------------
// kvd_front : input register and normal decode
// Takes vertex pairs, decodes both packed normals through the sine table and
// forms position deltas, producing one queue entry per item.
// ----------------------------------------------------------------------------
module kvd_front (
   input  logic                clock,
   input  logic                reset,
   kvd_req_if.sink             req,
   output logic                out_valid,
   output kvd_pkg::entry_type  out_entry,
   input  logic                out_ready
);

   localparam int PW = kvd_pkg::TPROD_W;

   // stage 1: raw item
   logic                                f1_v_ff, f1_v_in;
   logic signed [kvd_pkg::POS_IN_W-1:0] f1_cx_ff, f1_cy_ff, f1_cz_ff;
   logic signed [kvd_pkg::POS_IN_W-1:0] f1_nx_ff, f1_ny_ff, f1_nz_ff;
   logic [kvd_pkg::NRM_W-1:0]           f1_cn_ff, f1_nn_ff;

   // stage 2: deltas and trig products
   logic                                 f2_v_ff, f2_v_in;
   logic signed [kvd_pkg::POS_IN_W-1:0]  f2_cx_ff, f2_cy_ff, f2_cz_ff;
   logic signed [kvd_pkg::POS_DLT_W-1:0] f2_dx_ff, f2_dy_ff, f2_dz_ff;
   logic signed [kvd_pkg::POS_DLT_W-1:0] f2_dx_in, f2_dy_in, f2_dz_in;
   logic signed [PW-1:0]                 f2_cpx_ff, f2_cpy_ff, f2_npx_ff, f2_npy_ff;
   logic signed [PW-1:0]                 f2_cpx_in, f2_cpy_in, f2_npx_in, f2_npy_in;
   kvd_pkg::trig_type                    f2_cz_trig_ff, f2_nz_trig_ff;
   kvd_pkg::trig_type                    f2_cz_trig_in, f2_nz_trig_in;

   logic f1_rdy, f2_rdy;
   logic signed [PW-1:0] cpx_sh, cpy_sh, npx_sh, npy_sh;

   assign f2_rdy    = !f2_v_ff || out_ready;
   assign f1_rdy    = !f1_v_ff || f2_rdy;
   assign req.ready = f1_rdy;

   always_comb begin
      f1_v_in = f1_rdy ? req.valid : f1_v_ff;
      f2_v_in = f2_rdy ? f1_v_ff : f2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= f1_v_in;
         f2_v_ff <= f2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && f1_rdy) begin
         f1_cx_ff <= req.cur_x;
         f1_cy_ff <= req.cur_y;
         f1_cz_ff <= req.cur_z;
         f1_cn_ff <= req.cur_normal;
         f1_nx_ff <= req.next_x;
         f1_ny_ff <= req.next_y;
         f1_nz_ff <= req.next_z;
         f1_nn_ff <= req.next_normal;
      end
   end

   always_comb begin
      kvd_pkg::trig_type c_sl, c_cl, c_slat, n_sl, n_cl, n_slat;
      c_sl   = kvd_pkg::sine_at(f1_cn_ff[kvd_pkg::ANGLE_BITS-1:0]);
      c_cl   = kvd_pkg::cosine_at(f1_cn_ff[kvd_pkg::NRM_W-1:kvd_pkg::ANGLE_BITS]);
      c_slat = kvd_pkg::sine_at(f1_cn_ff[kvd_pkg::NRM_W-1:kvd_pkg::ANGLE_BITS]);
      n_sl   = kvd_pkg::sine_at(f1_nn_ff[kvd_pkg::ANGLE_BITS-1:0]);
      n_cl   = kvd_pkg::cosine_at(f1_nn_ff[kvd_pkg::NRM_W-1:kvd_pkg::ANGLE_BITS]);
      n_slat = kvd_pkg::sine_at(f1_nn_ff[kvd_pkg::NRM_W-1:kvd_pkg::ANGLE_BITS]);
      f2_cpx_in     = PW'(c_cl) * PW'(c_sl);
      f2_cpy_in     = PW'(c_slat) * PW'(c_sl);
      f2_npx_in     = PW'(n_cl) * PW'(n_sl);
      f2_npy_in     = PW'(n_slat) * PW'(n_sl);
      f2_cz_trig_in = kvd_pkg::cosine_at(f1_cn_ff[kvd_pkg::ANGLE_BITS-1:0]);
      f2_nz_trig_in = kvd_pkg::cosine_at(f1_nn_ff[kvd_pkg::ANGLE_BITS-1:0]);
      f2_dx_in = kvd_pkg::POS_DLT_W'(f1_nx_ff) - kvd_pkg::POS_DLT_W'(f1_cx_ff);
      f2_dy_in = kvd_pkg::POS_DLT_W'(f1_ny_ff) - kvd_pkg::POS_DLT_W'(f1_cy_ff);
      f2_dz_in = kvd_pkg::POS_DLT_W'(f1_nz_ff) - kvd_pkg::POS_DLT_W'(f1_cz_ff);
   end

   always_ff @(posedge clock) begin
      if (f1_v_ff && f2_rdy) begin
         f2_cx_ff      <= f1_cx_ff;
         f2_cy_ff      <= f1_cy_ff;
         f2_cz_ff      <= f1_cz_ff;
         f2_dx_ff      <= f2_dx_in;
         f2_dy_ff      <= f2_dy_in;
         f2_dz_ff      <= f2_dz_in;
         f2_cpx_ff     <= f2_cpx_in;
         f2_cpy_ff     <= f2_cpy_in;
         f2_npx_ff     <= f2_npx_in;
         f2_npy_ff     <= f2_npy_in;
         f2_cz_trig_ff <= f2_cz_trig_in;
         f2_nz_trig_ff <= f2_nz_trig_in;
      end
   end

   // floor by arithmetic shift
   assign cpx_sh = f2_cpx_ff >>> kvd_pkg::TRIG_FRAC_BITS;
   assign cpy_sh = f2_cpy_ff >>> kvd_pkg::TRIG_FRAC_BITS;
   assign npx_sh = f2_npx_ff >>> kvd_pkg::TRIG_FRAC_BITS;
   assign npy_sh = f2_npy_ff >>> kvd_pkg::TRIG_FRAC_BITS;

   always_comb begin
      out_entry.cur_x   = f2_cx_ff;
      out_entry.cur_y   = f2_cy_ff;
      out_entry.cur_z   = f2_cz_ff;
      out_entry.dlt_x   = f2_dx_ff;
      out_entry.dlt_y   = f2_dy_ff;
      out_entry.dlt_z   = f2_dz_ff;
      out_entry.ncur_x  = kvd_pkg::NRM_W'(cpx_sh);
      out_entry.ncur_y  = kvd_pkg::NRM_W'(cpy_sh);
      out_entry.ncur_z  = kvd_pkg::NRM_W'(f2_cz_trig_ff);
      out_entry.nnext_x = kvd_pkg::NRM_W'(npx_sh);
      out_entry.nnext_y = kvd_pkg::NRM_W'(npy_sh);
      out_entry.nnext_z = kvd_pkg::NRM_W'(f2_nz_trig_ff);
   end

   assign out_valid = f2_v_ff;

endmodule

FILE: rtl/kvd_queue.sv
// ----------------------------------------------------------------------------
// kvd_queue : decoded item queue
// Small FIFO between decode and lerp so either side can stall on its own.
// ----------------------------------------------------------------------------
module kvd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  kvd_pkg::entry_type  push_entry,
   output logic                push_ready,
   output logic                pop_valid,
   output kvd_pkg::entry_type  pop_entry,
   input  logic                pop_ready
);

   kvd_pkg::entry_type                mem_ff [kvd_pkg::QUEUE_DEPTH];
   logic [kvd_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [kvd_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [kvd_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;
   logic                              push, pop;

   assign push_ready = cnt_ff != kvd_pkg::QCNT_W'(kvd_pkg::QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + kvd_pkg::QCNT_W'(push) - kvd_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/kvd_back.sv
// ----------------------------------------------------------------------------
// kvd_back : keyframe lerp and output register
// Multiplies deltas by the interpolation factor, then floors and adds the
// current-frame values into the result register.
// ----------------------------------------------------------------------------
module kvd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  kvd_pkg::entry_type           in_entry,
   output logic                         in_ready,
   input  logic [kvd_pkg::FACT_W-1:0]   factor,
   kvd_rsp_if.source                    rsp
);

   localparam int LW = kvd_pkg::LPROD_W;

   logic                                b1_v_ff, b1_v_in, b2_v_ff, b2_v_in;
   logic b1_rdy, b2_rdy;

   logic signed [kvd_pkg::FACT_W:0]     tt;
   logic signed [kvd_pkg::NRM_DLT_W-1:0] dn_x, dn_y, dn_z;

   logic signed [LW-1:0]                b1_px_ff, b1_py_ff, b1_pz_ff;
   logic signed [LW-1:0]                b1_nx_ff, b1_ny_ff, b1_nz_ff;
   logic signed [LW-1:0]                b1_px_in, b1_py_in, b1_pz_in;
   logic signed [LW-1:0]                b1_nx_in, b1_ny_in, b1_nz_in;
   logic signed [kvd_pkg::POS_IN_W-1:0] b1_cx_ff, b1_cy_ff, b1_cz_ff;
   logic signed [kvd_pkg::NRM_W-1:0]    b1_ncx_ff, b1_ncy_ff, b1_ncz_ff;

   logic signed [LW-1:0]                 sum_px, sum_py, sum_pz;
   logic signed [LW-1:0]                 sum_nx, sum_ny, sum_nz;
   logic signed [kvd_pkg::POS_OUT_W-1:0] b2_px_ff, b2_py_ff, b2_pz_ff;
   logic signed [kvd_pkg::NRM_W-1:0]     b2_nx_ff, b2_ny_ff, b2_nz_ff;

   assign b2_rdy   = !b2_v_ff || rsp.ready;
   assign b1_rdy   = !b1_v_ff || b2_rdy;
   assign in_ready = b1_rdy;

   always_comb begin
      b1_v_in = b1_rdy ? in_valid : b1_v_ff;
      b2_v_in = b2_rdy ? b1_v_ff : b2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
      end else begin
         b1_v_ff <= b1_v_in;
         b2_v_ff <= b2_v_in;
      end
   end

   assign tt = signed'({1'b0, factor});

   always_comb begin
      dn_x = kvd_pkg::NRM_DLT_W'(in_entry.nnext_x) - kvd_pkg::NRM_DLT_W'(in_entry.ncur_x);
      dn_y = kvd_pkg::NRM_DLT_W'(in_entry.nnext_y) - kvd_pkg::NRM_DLT_W'(in_entry.ncur_y);
      dn_z = kvd_pkg::NRM_DLT_W'(in_entry.nnext_z) - kvd_pkg::NRM_DLT_W'(in_entry.ncur_z);
      b1_px_in = LW'(tt) * LW'(in_entry.dlt_x);
      b1_py_in = LW'(tt) * LW'(in_entry.dlt_y);
      b1_pz_in = LW'(tt) * LW'(in_entry.dlt_z);
      b1_nx_in = LW'(tt) * LW'(dn_x);
      b1_ny_in = LW'(tt) * LW'(dn_y);
      b1_nz_in = LW'(tt) * LW'(dn_z);
   end

   always_ff @(posedge clock) begin
      if (in_valid && b1_rdy) begin
         b1_px_ff  <= b1_px_in;
         b1_py_ff  <= b1_py_in;
         b1_pz_ff  <= b1_pz_in;
         b1_nx_ff  <= b1_nx_in;
         b1_ny_ff  <= b1_ny_in;
         b1_nz_ff  <= b1_nz_in;
         b1_cx_ff  <= in_entry.cur_x;
         b1_cy_ff  <= in_entry.cur_y;
         b1_cz_ff  <= in_entry.cur_z;
         b1_ncx_ff <= in_entry.ncur_x;
         b1_ncy_ff <= in_entry.ncur_y;
         b1_ncz_ff <= in_entry.ncur_z;
      end
   end

   always_comb begin
      sum_px = (LW'(b1_cx_ff) <<< kvd_pkg::POS_FRAC) + (b1_px_ff >>> kvd_pkg::POS_FRAC);
      sum_py = (LW'(b1_cy_ff) <<< kvd_pkg::POS_FRAC) + (b1_py_ff >>> kvd_pkg::POS_FRAC);
      sum_pz = (LW'(b1_cz_ff) <<< kvd_pkg::POS_FRAC) + (b1_pz_ff >>> kvd_pkg::POS_FRAC);
      sum_nx = LW'(b1_ncx_ff) + (b1_nx_ff >>> kvd_pkg::LERP_SHIFT);
      sum_ny = LW'(b1_ncy_ff) + (b1_ny_ff >>> kvd_pkg::LERP_SHIFT);
      sum_nz = LW'(b1_ncz_ff) + (b1_nz_ff >>> kvd_pkg::LERP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (b1_v_ff && b2_rdy) begin
         b2_px_ff <= sum_px[kvd_pkg::POS_OUT_W-1:0];
         b2_py_ff <= sum_py[kvd_pkg::POS_OUT_W-1:0];
         b2_pz_ff <= sum_pz[kvd_pkg::POS_OUT_W-1:0];
         b2_nx_ff <= sum_nx[kvd_pkg::NRM_W-1:0];
         b2_ny_ff <= sum_ny[kvd_pkg::NRM_W-1:0];
         b2_nz_ff <= sum_nz[kvd_pkg::NRM_W-1:0];
      end
   end

   assign rsp.valid = b2_v_ff;
   assign rsp.pos_x = b2_px_ff;
   assign rsp.pos_y = b2_py_ff;
   assign rsp.pos_z = b2_pz_ff;
   assign rsp.nrm_x = b2_nx_ff;
   assign rsp.nrm_y = b2_ny_ff;
   assign rsp.nrm_z = b2_nz_ff;

endmodule

FILE: rtl/keyframe_vertex_decode_lerp_unit.sv
// ----------------------------------------------------------------------------
// keyframe_vertex_decode_lerp_unit : vertex pair decode and keyframe lerp
// Takes one vertex in two keyframes per item, returns the interpolated
// position and normal.
// ----------------------------------------------------------------------------
// Sustains one item per clock while nothing stalls. Each item passes through
// two decode stages (input register, then the
// sine-table lookups and normal products), a four-entry queue, then the lerp
// multiply stage and the output register. Each multiplier set has a stage of
// its own, which sets the pipeline depth. Up to eight items can be in flight.
// The factor is sampled as items pass the lerp stage, so write it only while
// the block is drained; values above 1.0 are saturated to 1.0.
// ----------------------------------------------------------------------------
module keyframe_vertex_decode_lerp_unit (
   input  logic                        clock,
   input  logic                        reset,
   kvd_req_if.sink                     req_bus,
   kvd_rsp_if.source                   rsp_bus,
   input  logic                        csr_write_en,
   input  logic [kvd_pkg::FACT_W-1:0]  csr_write_data
);

   logic [kvd_pkg::FACT_W-1:0] factor_ff, factor_in;
   logic [kvd_pkg::FACT_W-1:0] factor_sat;

   logic               fq_valid, fq_ready;
   kvd_pkg::entry_type fq_entry;
   logic               qb_valid, qb_ready;
   kvd_pkg::entry_type qb_entry;

   assign factor_in = csr_write_en ? csr_write_data : factor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= '0;
      end else begin
         factor_ff <= factor_in;
      end
   end

   assign factor_sat = (factor_ff > kvd_pkg::FACT_W'(kvd_pkg::ONE_Q16))
                       ? kvd_pkg::FACT_W'(kvd_pkg::ONE_Q16) : factor_ff;

   kvd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .out_valid (fq_valid),
      .out_entry (fq_entry),
      .out_ready (fq_ready)
   );

   kvd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_entry (fq_entry),
      .push_ready (fq_ready),
      .pop_valid  (qb_valid),
      .pop_entry  (qb_entry),
      .pop_ready  (qb_ready)
   );

   kvd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (qb_valid),
      .in_entry (qb_entry),
      .in_ready (qb_ready),
      .factor   (factor_sat),
      .rsp      (rsp_bus)
   );

endmodule

FILE: rtl/kvd_checker.sv
// ----------------------------------------------------------------------------
// kvd_checker : port-level checks for the decode and lerp unit
// Watches the top-level channels and tracks items in flight.
// ----------------------------------------------------------------------------
module kvd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [kvd_pkg::POS_OUT_W-1:0] pos_x,
   input logic signed [kvd_pkg::POS_OUT_W-1:0] pos_y,
   input logic signed [kvd_pkg::POS_OUT_W-1:0] pos_z,
   input logic signed [kvd_pkg::NRM_W-1:0]     nrm_x,
   input logic signed [kvd_pkg::NRM_W-1:0]     nrm_y,
   input logic signed [kvd_pkg::NRM_W-1:0]     nrm_z
);

   localparam int CAPACITY = kvd_pkg::QUEUE_DEPTH + 4;
   localparam int CNT_W    = $clog2(CAPACITY + 1) + 1;
   localparam logic signed [kvd_pkg::NRM_W-1:0] NRM_MAX = kvd_pkg::NRM_W'(1 << 14);
   localparam logic signed [kvd_pkg::NRM_W-1:0] NRM_MIN = -NRM_MAX;

   logic             req_fire, rsp_fire;
   logic [CNT_W-1:0] inflight_ff, inflight_in;

   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign inflight_in = inflight_ff + CNT_W'(req_fire) - CNT_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z}))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> inflight_ff != '0)
      else $error("result without an item in flight");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(CAPACITY))
      else $error("more items in flight than pipeline holds");

   a_nrm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> nrm_x >= NRM_MIN && nrm_x <= NRM_MAX &&
                    nrm_y >= NRM_MIN && nrm_y <= NRM_MAX &&
                    nrm_z >= NRM_MIN && nrm_z <= NRM_MAX)
      else $error("normal component out of unit range");

endmodule

bind keyframe_vertex_decode_lerp_unit kvd_checker u_kvd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .pos_x     (rsp_bus.pos_x),
   .pos_y     (rsp_bus.pos_y),
   .pos_z     (rsp_bus.pos_z),
   .nrm_x     (rsp_bus.nrm_x),
   .nrm_y     (rsp_bus.nrm_y),
   .nrm_z     (rsp_bus.nrm_z)
);

FILE: test/vertex_lerp_checker.sv
// ----------------------------------------------------------------------------
// vertex_lerp_checker : result checker for the keyframe vertex lerp unit
// Watches the vertex pair and result channels and the factor register port.
// It predicts each lerped vertex from its own sine table and copy of the
// factor, then compares every returned item field by field, oldest first.
// ----------------------------------------------------------------------------
module vertex_lerp_checker
   import kvd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   kvd_req_if                req_mon,
   kvd_rsp_if                rsp_mon,
   input  logic              csr_write_en,
   input  logic [FACT_W-1:0] csr_write_data,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [POS_OUT_W-1:0] pos_x;
      logic signed [POS_OUT_W-1:0] pos_y;
      logic signed [POS_OUT_W-1:0] pos_z;
      logic signed [NRM_W-1:0]     nrm_x;
      logic signed [NRM_W-1:0]     nrm_y;
      logic signed [NRM_W-1:0]     nrm_z;
   } lerped_vertex_type;

   longint            quarter_wave [0:QUARTER_TURN];
   lerped_vertex_type expected_vertices [$];
   logic [FACT_W-1:0] lerp_factor;

   initial begin
      longint ang;
      longint ang_sq;
      longint term;
      longint acc;
      longint q;
      // quarter wave of sin(k*pi/128): Taylor series in Q30, then rounded
      for (int k = 0; k <= QUARTER_TURN; k++) begin
         ang    = (PI_Q30 * longint'(k)) / HALF_TURN;
         ang_sq = (ang * ang) >>> 30;
         term   = ang;
         acc    = ang;
         for (int n = 1; n <= 12; n++) begin
            term = (term * ang_sq) >>> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - term : acc + term;
         end
         if (acc < 0) begin
            acc = 0;
         end
         q = (acc + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
         if (q > (longint'(1) << TRIG_FRAC_BITS)) begin
            q = longint'(1) << TRIG_FRAC_BITS;
         end
         quarter_wave[k] = q;
      end
   end

   function automatic longint sin_step(input int k);
      int a;
      a = k & (ANGLE_STEPS - 1);
      if (a <= QUARTER_TURN) begin
         return quarter_wave[a];
      end
      if (a <= HALF_TURN) begin
         return quarter_wave[HALF_TURN - a];
      end
      if (a <= HALF_TURN + QUARTER_TURN) begin
         return -quarter_wave[a - HALF_TURN];
      end
      return -quarter_wave[ANGLE_STEPS - a];
   endfunction

   function automatic longint cos_step(input int k);
      return sin_step(k + QUARTER_TURN);
   endfunction

   function automatic void decode_normal(input logic [NRM_W-1:0] code,
                                         output longint nx, output longint ny,
                                         output longint nz);
      int     lat;
      int     lng;
      longint s_lng;
      lat   = int'(code[15:8]);
      lng   = int'(code[7:0]);
      s_lng = sin_step(lng);
      nx    = (cos_step(lat) * s_lng) >>> TRIG_FRAC_BITS;
      ny    = (sin_step(lat) * s_lng) >>> TRIG_FRAC_BITS;
      nz    = cos_step(lng);
   endfunction

   function automatic longint lerp_position(input longint c, input longint n,
                                            input longint w);
      return c * 256 + ((w * (n - c)) >>> POS_FRAC);
   endfunction

   function automatic longint lerp_normal(input longint c, input longint n,
                                          input longint w);
      return c + ((w * (n - c)) >>> LERP_SHIFT);
   endfunction

   function automatic lerped_vertex_type predict_vertex(
      input longint cur_x, input longint cur_y, input longint cur_z,
      input logic [NRM_W-1:0] cur_code,
      input longint next_x, input longint next_y, input longint next_z,
      input logic [NRM_W-1:0] next_code,
      input logic [FACT_W-1:0] factor);
      lerped_vertex_type r;
      longint            w;
      longint            cx, cy, cz;
      longint            nx, ny, nz;
      // factor above one saturates
      w = (factor > ONE_Q16) ? longint'(ONE_Q16) : longint'(factor);
      r.pos_x = POS_OUT_W'(lerp_position(cur_x, next_x, w));
      r.pos_y = POS_OUT_W'(lerp_position(cur_y, next_y, w));
      r.pos_z = POS_OUT_W'(lerp_position(cur_z, next_z, w));
      decode_normal(cur_code, cx, cy, cz);
      decode_normal(next_code, nx, ny, nz);
      r.nrm_x = NRM_W'(lerp_normal(cx, nx, w));
      r.nrm_y = NRM_W'(lerp_normal(cy, ny, w));
      r.nrm_z = NRM_W'(lerp_normal(cz, nz, w));
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string field, input longint got,
                              input longint want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
      end
   endtask

   always @(posedge clock) begin
      lerped_vertex_type want;
      if (reset) begin
         expected_vertices.delete();
         lerp_factor = '0;
         fail_count  = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_vertices.size() == 0) begin
               report_mismatch("result item with no vertex pending");
            end else begin
               want = expected_vertices.pop_front();
               check_field("pos_x", longint'(rsp_mon.pos_x), longint'(want.pos_x));
               check_field("pos_y", longint'(rsp_mon.pos_y), longint'(want.pos_y));
               check_field("pos_z", longint'(rsp_mon.pos_z), longint'(want.pos_z));
               check_field("nrm_x", longint'(rsp_mon.nrm_x), longint'(want.nrm_x));
               check_field("nrm_y", longint'(rsp_mon.nrm_y), longint'(want.nrm_y));
               check_field("nrm_z", longint'(rsp_mon.nrm_z), longint'(want.nrm_z));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_vertices.insert(expected_vertices.size(), predict_vertex(
               longint'(req_mon.cur_x), longint'(req_mon.cur_y),
               longint'(req_mon.cur_z), req_mon.cur_normal,
               longint'(req_mon.next_x), longint'(req_mon.next_y),
               longint'(req_mon.next_z), req_mon.next_normal, lerp_factor));
         end
         if (csr_write_en) begin
            lerp_factor = csr_write_data;
         end
      end
      pending = expected_vertices.size();
   end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench : keyframe vertex decode and lerp unit
// Drives vertex pairs with random gaps and result stalls, one long hold-off
// on the result side, and a run of factor settings including zero, one and
// saturating values. The checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import kvd_pkg::*;

   localparam int IDLE_PCT      = 38;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 85;
   localparam int STEADY_PHASE  = 3;
   localparam int HOLD_AT       = 480;
   localparam int HOLD_CYCLES   = 250;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 4000;
   localparam int FACTOR_MAX    = (1 << FACT_W) - 1;
   localparam int EDGE_ANGLES [12] = '{0, 1, 63, 64, 65, 127, 128, 129,
                                       191, 192, 193, 255};

   typedef struct packed {
      logic signed [POS_IN_W-1:0] cur_x;
      logic signed [POS_IN_W-1:0] cur_y;
      logic signed [POS_IN_W-1:0] cur_z;
      logic [NRM_W-1:0]           cur_normal;
      logic signed [POS_IN_W-1:0] next_x;
      logic signed [POS_IN_W-1:0] next_y;
      logic signed [POS_IN_W-1:0] next_z;
      logic [NRM_W-1:0]           next_normal;
   } vertex_pair_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write_en;
   logic [FACT_W-1:0] csr_write_data;
   int                fail_count;
   int                pending;
   int                items_sent;
   bit                steady;

   kvd_req_if req_bus();
   kvd_rsp_if rsp_bus();

   keyframe_vertex_decode_lerp_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   vertex_lerp_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   always #5 clock = ~clock;

   function automatic vertex_pair_type vertex_of(input int cx, input int cy, input int cz,
                                                 input int cn, input int nx, input int ny,
                                                 input int nz, input int nn);
      vertex_pair_type v;
      v.cur_x       = POS_IN_W'(cx);
      v.cur_y       = POS_IN_W'(cy);
      v.cur_z       = POS_IN_W'(cz);
      v.cur_normal  = NRM_W'(cn);
      v.next_x      = POS_IN_W'(nx);
      v.next_y      = POS_IN_W'(ny);
      v.next_z      = POS_IN_W'(nz);
      v.next_normal = NRM_W'(nn);
      return v;
   endfunction

   function automatic int edge_position();
      case ($urandom_range(6))
         0: return -32768;
         1: return -32767;
         2: return -1;
         3: return 0;
         4: return 1;
         5: return 32766;
         default: return 32767;
      endcase
   endfunction

   function automatic int edge_normal();
      return (EDGE_ANGLES[$urandom_range(11)] << 8) | EDGE_ANGLES[$urandom_range(11)];
   endfunction

   function automatic vertex_pair_type random_vertex();
      vertex_pair_type v;
      int              sel;
      v   = vertex_of($urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
      sel = $urandom_range(99);
      if (sel < 15) begin
         v.cur_x  = POS_IN_W'(edge_position());
         v.cur_y  = POS_IN_W'(edge_position());
         v.cur_z  = POS_IN_W'(edge_position());
         v.next_x = POS_IN_W'(edge_position());
         v.next_y = POS_IN_W'(edge_position());
         v.next_z = POS_IN_W'(edge_position());
      end else if (sel < 30) begin
         v.cur_normal  = NRM_W'(edge_normal());
         v.next_normal = NRM_W'(edge_normal());
      end
      return v;
   endfunction

   function automatic int phase_factor(input int phase);
      case (phase)
         0: return 0;
         1: return ONE_Q16;
         2: return FACTOR_MAX;
         3: return ONE_Q16 / 2;
         4: return 1;
         5: return ONE_Q16 - 1;
         6: return ONE_Q16 + 1;
         default: return $urandom_range(ONE_Q16);
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_vertex(input vertex_pair_type v);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.cur_x       <= v.cur_x;
      req_bus.cur_y       <= v.cur_y;
      req_bus.cur_z       <= v.cur_z;
      req_bus.cur_normal  <= v.cur_normal;
      req_bus.next_x      <= v.next_x;
      req_bus.next_y      <= v.next_y;
      req_bus.next_z      <= v.next_z;
      req_bus.next_normal <= v.next_normal;
      req_bus.valid       <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      items_sent++;
      @(negedge clock);
   endtask

   // factor is only changed with the unit drained
   task automatic set_factor(input int value);
      req_bus.valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= FACT_W'(value);
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.cur_x       = '0;
      req_bus.cur_y       = '0;
      req_bus.cur_z       = '0;
      req_bus.cur_normal  = '0;
      req_bus.next_x      = '0;
      req_bus.next_y      = '0;
      req_bus.next_z      = '0;
      req_bus.next_normal = '0;
      items_sent          = 0;
      steady              = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_factor(40000);
      send_vertex(vertex_of(0, 0, 0, 16'h0000, 0, 0, 0, 16'h0000));
      send_vertex(vertex_of(-32768, -32768, -32768, 16'h0000,
                            32767, 32767, 32767, 16'hFFFF));
      send_vertex(vertex_of(32767, 32767, 32767, 16'hFFFF,
                            -32768, -32768, -32768, 16'h0000));
      send_vertex(vertex_of(32767, -32768, -1, 16'h4040, 32767, -32768, 0, 16'hC0C0));
      send_vertex(vertex_of(-1, 1, 0, 16'h0040, 0, -1, 1, 16'h0080));
      // quadrant boundaries of both angles
      for (int i = 0; i < 12; i++) begin
         send_vertex(vertex_of($urandom, $urandom, $urandom,
                               (EDGE_ANGLES[i] << 8) | EDGE_ANGLES[(i + 5) % 12],
                               $urandom, $urandom, $urandom,
                               (EDGE_ANGLES[(i + 7) % 12] << 8) | EDGE_ANGLES[i]));
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         set_factor(phase_factor(phase));
         steady = (phase == STEADY_PHASE);
         repeat (PHASE_ITEMS) send_vertex(random_vertex());
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off while items keep coming
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left     = 0;
      hold_done     = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (steady) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) ||
             (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
